[design/igmod_pkg.sv]
// Shared types, constants and helpers for the IGM optical depth pipeline.
package igmod_pkg;

    typedef struct packed {
        logic [23:0] wavelength;
        logic [16:0] redshift;
        logic        last_bin;
    } t_in;

    typedef struct packed {
        logic [23:0] optical_depth;
        logic        last_out;
    } t_out;

    // pipeline depth, input register through output register
    localparam int NST    = 33;
    localparam int N_POW  = 14;
    localparam int N_LG   = 6;
    localparam int PROD_W = 41;
    localparam int POW_W  = 41;
    localparam int SUM_W  = 48;

    // log2 source lanes: 0..3 line ratios, then x = lambda/912, then 1+z
    localparam int LG_X = 4;
    localparam int LG_Z = 5;

    // power lanes
    localparam int PW_X3   = 4;
    localparam int PW_X15  = 5;
    localparam int PW_Z046 = 6;
    localparam int PW_Z018 = 8;
    localparam int PW_Z132 = 10;
    localparam int PW_Z168 = 12;

    localparam int POW_SRC [0:N_POW-1] = '{
        0, 1, 2, 3, LG_X, LG_X, LG_Z, LG_X, LG_Z, LG_X, LG_Z, LG_X, LG_Z, LG_X
    };

    localparam logic signed [18:0] POW_EXPO [0:N_POW-1] = '{
        19'sd226755, 19'sd226755, 19'sd226755, 19'sd226755,
        19'sd196608, 19'sd98304,
        19'sd30147,  19'sd30147,
        19'sd11796,  19'sd11796,
        -19'sd86508, -19'sd86508,
        19'sd110100, 19'sd110100
    };

    // 16 * line wavelength: 1216, 1026, 973, 950, 912
    localparam logic [15:0] LEN16 [0:4] = '{
        16'd19456, 16'd16416, 16'd15568, 16'd15200, 16'd14592
    };

    localparam logic [15:0] LINE_COEF [0:3] = '{
        16'd60398, 16'd28521, 16'd20133, 16'd15603
    };

    localparam logic signed [28:0] COEF_C2 = 29'sd157705830;
    localparam logic signed [24:0] COEF_C3 = 25'sd11744051;
    localparam logic signed [19:0] COEF_C4 = 20'sd385876;
    localparam int                 C1_SHL  = 6;

    localparam logic [31:0] TAYLOR [0:5] = '{
        32'd744261118, 32'd257941248, 32'd59597083,
        32'd10327387,  32'd1431680,   32'd165394
    };
    localparam logic [31:0] ONE30 = 32'h4000_0000;

    localparam logic signed [25:0] E_MIN  = -26'sd2621440;
    localparam logic signed [25:0] E_MAX  = 26'sd1441792;
    localparam logic signed [25:0] E_BIAS = 26'sd4194304;
    localparam logic [6:0]         NB14   = 7'd78;

    localparam logic [23:0] MAXOUT = 24'hFF_FFFF;

    // Q16 log2 of a constant, same squaring scheme as the datapath
    function automatic int log2q_c(input int unsigned v);
        int                k;
        int                i;
        int                fr;
        longint unsigned   m;
        k = 0;
        for (i = 0; i < 32; i++) begin
            if (v[i]) k = i;
        end
        m  = longint'(v) << (30 - k);
        fr = 0;
        for (i = 0; i < 16; i++) begin
            m  = (m * m) >> 30;
            fr = fr << 1;
            if (m >= 64'h8000_0000) begin
                m  = m >> 1;
                fr = fr | 1;
            end
        end
        return k * 65536 + fr;
    endfunction

    localparam logic signed [21:0] LOG16L [0:4] = '{
        22'(log2q_c(19456)), 22'(log2q_c(16416)), 22'(log2q_c(15568)),
        22'(log2q_c(15200)), 22'(log2q_c(14592))
    };
    localparam logic signed [21:0] LOG_ZS_OFF = 22'sd786432;

    // divide by 65536, truncating toward zero
    function automatic logic signed [71:0] divtz16(input logic signed [71:0] p);
        logic signed [71:0] a;
        a = p[71] ? p + 72'sd65535 : p;
        return a >>> 16;
    endfunction

endpackage

[design/igm_optical_depth_top.sv]
// IGM optical depth: 33-stage pipeline, one wavelength bin per cycle.
// An accepted beat is registered in every stage in turn, from r_w and r_meta[0] through r_out.
// Throughput: one beat per cycle; the 16 log2 squaring stages and 8-stage exp2
// units set the depth. A held output beat freezes the whole pipeline.
// Reset (synchronous, active low) clears all stage valid bits.
module igm_optical_depth_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  igmod_pkg::t_in    i_in_data,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output igmod_pkg::t_out   o_out_data,
    input  logic              i_out_stall
);

    typedef struct packed {
        logic       valid;
        logic       last;
        logic [2:0] nlines;
        logic       cont;
    } t_meta;

    logic  en;
    t_meta r_meta [0:igmod_pkg::NST-1];
    t_meta n_meta1;

    // stage 0
    logic [23:0] r_w;
    logic [17:0] r_zs;

    // window compares
    logic [35:0] s_val;
    logic [35:0] b_val [0:4];

    // log2 lanes: 0 wavelength, 1 1+z
    logic [23:0] lv [0:1];
    logic [4:0]  lk [0:1];
    logic [30:0] lm [0:1];
    logic [61:0] sq [1:16][0:1];
    logic [30:0] sm [1:16][0:1];
    logic        sb [1:16][0:1];
    logic [30:0] r_lm [0:16][0:1];
    logic [15:0] r_lf [0:16][0:1];
    logic [4:0]  r_lk [0:16][0:1];

    logic signed [21:0] n_lg [0:igmod_pkg::N_LG-1];
    logic signed [21:0] r_lg [0:igmod_pkg::N_LG-1];
    logic signed [igmod_pkg::PROD_W-1:0] r_prod [0:igmod_pkg::N_POW-1];
    logic [igmod_pkg::POW_W-1:0] w_pow [0:igmod_pkg::N_POW-1];

    // tail
    logic [56:0]        r_line_p [0:3];
    logic [40:0]        r_line_t [0:3];
    logic [31:0]        r_x3;
    logic [24:0]        r_x15;
    logic signed [26:0] r_d [0:3];
    logic signed [59:0] m_t1;
    logic signed [52:0] m_t2;
    logic signed [59:0] m_t3;
    logic signed [46:0] m_t4;
    logic signed [65:0] m_c2;
    logic signed [68:0] m_c3;
    logic signed [43:0] r_t1;
    logic signed [36:0] r_t2;
    logic signed [43:0] r_t3;
    logic signed [30:0] r_t4;
    logic signed [igmod_pkg::SUM_W-1:0] lsum;
    logic signed [igmod_pkg::SUM_W-1:0] r_lsum;
    logic signed [igmod_pkg::SUM_W-1:0] r_c1;
    logic signed [igmod_pkg::SUM_W-1:0] r_c2;
    logic signed [igmod_pkg::SUM_W-1:0] r_c3;
    logic signed [igmod_pkg::SUM_W-1:0] r_c4;
    logic signed [igmod_pkg::SUM_W-1:0] r_sum;
    logic signed [igmod_pkg::SUM_W-1:0] sum_adj;
    logic [35:0]        rnd;
    igmod_pkg::t_out    n_out;
    igmod_pkg::t_out    r_out;

    assign en          = !(r_meta[igmod_pkg::NST-1].valid && i_out_stall);
    assign o_in_stall  = !en;
    assign o_out_valid = r_meta[igmod_pkg::NST-1].valid;
    assign o_out_data  = r_out;

    // window classification, on a shared bound the first matching window (more lines) wins
    always_comb begin
        s_val = {r_w, 12'd0};
        for (int j = 0; j < 5; j++) begin
            b_val[j] = 36'(igmod_pkg::LEN16[j]) * 36'(r_zs);
        end
        n_meta1        = r_meta[0];
        n_meta1.nlines = 3'd0;
        n_meta1.cont   = 1'b0;
        if (r_w >= 24'(igmod_pkg::LEN16[4]) && s_val <= b_val[4]) begin
            n_meta1.nlines = 3'd4;
            n_meta1.cont   = 1'b1;
        end else if (b_val[4] <= s_val && s_val <= b_val[3]) begin
            n_meta1.nlines = 3'd4;
        end else if (b_val[3] <= s_val && s_val <= b_val[2]) begin
            n_meta1.nlines = 3'd3;
        end else if (b_val[2] <= s_val && s_val <= b_val[1]) begin
            n_meta1.nlines = 3'd2;
        end else if (b_val[1] <= s_val && s_val <= b_val[0]) begin
            n_meta1.nlines = 3'd1;
        end
    end

    // normalize to Q30 mantissa, msb index as integer part
    always_comb begin
        lv[0] = r_w;
        lv[1] = 24'(r_zs);
        for (int l = 0; l < 2; l++) begin
            lk[l] = '0;
            for (int i = 0; i < 24; i++) begin
                if (lv[l][i]) lk[l] = 5'(i);
            end
            lm[l] = 31'(lv[l]) << (5'd30 - lk[l]);
        end
    end

    // one fraction bit per stage by squaring
    always_comb begin
        for (int s = 1; s <= 16; s++) begin
            for (int l = 0; l < 2; l++) begin
                sq[s][l] = 62'(r_lm[s-1][l]) * 62'(r_lm[s-1][l]);
                if (sq[s][l][61]) begin
                    sm[s][l] = sq[s][l][61:31];
                    sb[s][l] = 1'b1;
                end else begin
                    sm[s][l] = sq[s][l][60:30];
                    sb[s][l] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        for (int j = 0; j < 5; j++) begin
            n_lg[j] = $signed({1'b0, r_lk[16][0], r_lf[16][0]}) - igmod_pkg::LOG16L[j];
        end
        n_lg[igmod_pkg::LG_Z] = $signed({1'b0, r_lk[16][1], r_lf[16][1]})
                                - igmod_pkg::LOG_ZS_OFF;
    end

    for (genvar g = 0; g < igmod_pkg::N_POW; g++) begin : g_pow
        igmod_exp2 u_exp2 (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_prod (r_prod[g]),
            .o_pow  (w_pow[g])
        );
    end

    always_comb begin
        m_t1 = $signed({1'b0, r_x3}) * r_d[0];
        m_t2 = $signed({1'b0, r_x15}) * r_d[1];
        m_t3 = $signed({1'b0, r_x3}) * r_d[2];
        m_t4 = igmod_pkg::COEF_C4 * r_d[3];
        m_c2 = igmod_pkg::COEF_C2 * r_t2;
        m_c3 = igmod_pkg::COEF_C3 * r_t3;
        lsum = '0;
        for (int j = 0; j < 4; j++) begin
            if (3'(j) < r_meta[29].nlines) begin
                lsum = lsum + $signed({7'd0, r_line_t[j]});
            end
        end
    end

    always_comb begin
        sum_adj = r_sum + 48'sd2048;
        rnd     = sum_adj[47:12];
        n_out.last_out = r_meta[igmod_pkg::NST-2].last;
        if (r_sum > 0) begin
            n_out.optical_depth = (rnd > 36'(igmod_pkg::MAXOUT)) ? igmod_pkg::MAXOUT
                                                                 : rnd[23:0];
        end else begin
            n_out.optical_depth = '0;
        end
    end

    // control: valid and side info travel with the beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < igmod_pkg::NST; i++) r_meta[i] <= '0;
        end else if (en) begin
            r_meta[0] <= '{valid: i_in_valid, last: i_in_data.last_bin,
                           nlines: 3'd0, cont: 1'b0};
            r_meta[1] <= n_meta1;
            for (int i = 2; i < igmod_pkg::NST; i++) r_meta[i] <= r_meta[i-1];
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w  <= i_in_data.wavelength;
            r_zs <= 18'(i_in_data.redshift) + 18'd4096;

            for (int l = 0; l < 2; l++) begin
                r_lm[0][l] <= lm[l];
                r_lf[0][l] <= '0;
                r_lk[0][l] <= lk[l];
                for (int s = 1; s <= 16; s++) begin
                    r_lm[s][l] <= sm[s][l];
                    r_lf[s][l] <= {r_lf[s-1][l][14:0], sb[s][l]};
                    r_lk[s][l] <= r_lk[s-1][l];
                end
            end

            for (int j = 0; j < igmod_pkg::N_LG; j++) r_lg[j] <= n_lg[j];
            for (int i = 0; i < igmod_pkg::N_POW; i++) begin
                r_prod[i] <= r_lg[igmod_pkg::POW_SRC[i]] * igmod_pkg::POW_EXPO[i];
            end

            for (int j = 0; j < 4; j++) begin
                r_line_p[j] <= 57'(igmod_pkg::LINE_COEF[j]) * 57'(w_pow[j]);
                r_line_t[j] <= r_line_p[j][56:16];
                r_d[j] <= $signed({1'b0, w_pow[igmod_pkg::PW_Z046 + 2*j][25:0]})
                        - $signed({1'b0, w_pow[igmod_pkg::PW_Z046 + 2*j + 1][25:0]});
            end
            r_x3  <= w_pow[igmod_pkg::PW_X3][31:0];
            r_x15 <= w_pow[igmod_pkg::PW_X15][24:0];

            r_t1 <= 44'(igmod_pkg::divtz16(72'(m_t1)));
            r_t2 <= 37'(igmod_pkg::divtz16(72'(m_t2)));
            r_t3 <= 44'(igmod_pkg::divtz16(72'(m_t3)));
            r_t4 <= 31'(igmod_pkg::divtz16(72'(m_t4)));

            r_c1   <= 48'(r_t1) <<< igmod_pkg::C1_SHL;
            r_c2   <= 48'(igmod_pkg::divtz16(72'(m_c2)));
            r_c3   <= 48'(igmod_pkg::divtz16(72'(m_c3)));
            r_c4   <= 48'(r_t4);
            r_lsum <= lsum;

            r_sum <= r_meta[30].cont ? r_lsum + r_c1 + r_c2 + r_c3 - r_c4 : r_lsum;

            r_out <= n_out;
        end
    end

endmodule

[design/igmod_exp2.sv]
// Pipelined Q16 exp2: range clamp, six Horner steps, final scaling shift.
module igmod_exp2 (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic signed [igmod_pkg::PROD_W-1:0]    i_prod,
    output logic        [igmod_pkg::POW_W-1:0]     o_pow
);

    logic signed [25:0] ea;
    logic signed [25:0] ec;
    logic [22:0]        eu;

    logic [32:0] r_p  [1:6];
    logic [29:0] r_f  [0:5];
    logic [6:0]  r_nb [0:6];
    logic        r_z  [0:6];
    logic [igmod_pkg::POW_W-1:0] r_out;
    logic [igmod_pkg::POW_W-1:0] pw;

    always_comb begin
        ea = 26'(igmod_pkg::divtz16(72'(i_prod)));
        ec = (ea > igmod_pkg::E_MAX) ? igmod_pkg::E_MAX : ea;
        eu = 23'(ec + igmod_pkg::E_BIAS);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z[0]  <= (ea < igmod_pkg::E_MIN);
            r_nb[0] <= eu[22:16];
            r_f[0]  <= {eu[15:0], 14'd0};
        end
    end

    for (genvar s = 1; s <= 6; s++) begin : g_hs
        logic [32:0] p_in;
        logic [62:0] mul;
        logic [32:0] p_nx;

        if (s == 1) begin : g_first
            assign p_in = 33'(igmod_pkg::TAYLOR[5]);
        end else begin : g_rest
            assign p_in = r_p[s-1];
        end

        assign mul = 63'(p_in) * 63'(r_f[s-1]);

        if (s == 6) begin : g_last
            assign p_nx = 33'(igmod_pkg::ONE30) + mul[62:30];
        end else begin : g_mid
            assign p_nx = 33'(igmod_pkg::TAYLOR[5-s]) + mul[62:30];
            always_ff @(posedge i_clk) begin
                if (i_en) r_f[s] <= r_f[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p[s]  <= p_nx;
                r_nb[s] <= r_nb[s-1];
                r_z[s]  <= r_z[s-1];
            end
        end
    end

    // biased exponent 78 means 2^f lands directly in Q16
    always_comb begin
        if (r_nb[6] >= igmod_pkg::NB14) begin
            pw = 41'(r_p[6]) << (r_nb[6] - igmod_pkg::NB14);
        end else begin
            pw = 41'(r_p[6]) >> (igmod_pkg::NB14 - r_nb[6]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_out <= r_z[6] ? '0 : pw;
    end

    assign o_pow = r_out;

endmodule
